>>> design/csm_pkg.sv
// Shared constants, types and saturation helpers for the CIGAR string metrics block.
`timescale 1ns / 1ps
`default_nettype none

package csm_pkg;

    localparam int RUN_BITS  = 28;
    localparam int SUM_BITS  = 32;
    localparam int OUT_BITS  = 32;
    localparam int CLIP_BITS = 28;
    localparam int CHAR_BITS = 8;

    localparam int ADD_BITS  = ((SUM_BITS > RUN_BITS) ? SUM_BITS : RUN_BITS) + 1;
    localparam int OC_BITS   = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS;
    localparam int CC_BITS   = (RUN_BITS > CLIP_BITS) ? RUN_BITS : CLIP_BITS;
    localparam int PROD_BITS = RUN_BITS + 4;

    localparam logic [RUN_BITS-1:0]  RUN_MAX  = '1;
    localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;
    localparam logic [OUT_BITS-1:0]  OUT_MAX  = '1;
    localparam logic [CLIP_BITS-1:0] CLIP_MAX = '1;
    localparam logic [3:0]           DEC_BASE = 4'd10;

    localparam logic [CHAR_BITS-1:0] CH_M  = 8'h4D;
    localparam logic [CHAR_BITS-1:0] CH_D  = 8'h44;
    localparam logic [CHAR_BITS-1:0] CH_N  = 8'h4E;
    localparam logic [CHAR_BITS-1:0] CH_EQ = 8'h3D;
    localparam logic [CHAR_BITS-1:0] CH_X  = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_I  = 8'h49;
    localparam logic [CHAR_BITS-1:0] CH_S  = 8'h53;
    localparam logic [CHAR_BITS-1:0] CH_H  = 8'h48;
    localparam logic [CHAR_BITS-1:0] CH_0  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_9  = 8'h39;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_SOFT  = 2'd1,
        KIND_HARD  = 2'd2
    } t_op_kind;

    typedef struct packed {
        logic [CHAR_BITS-1:0] cigar_char;
        logic                 last_char;
    } t_char_req;

    typedef struct packed {
        logic [CLIP_BITS-1:0] clip_right;
        logic [CLIP_BITS-1:0] clip_left;
        logic [OUT_BITS-1:0]  query_length;
        logic [OUT_BITS-1:0]  ref_span;
    } t_metrics_data;

    typedef struct packed {
        t_metrics_data data;
        logic          dangling_digits;
    } t_metrics;

    function automatic logic [SUM_BITS-1:0] sum_sat_add(
        input logic [SUM_BITS-1:0] sum,
        input logic [RUN_BITS-1:0] len
    );
        logic [ADD_BITS-1:0] s;
        s = ADD_BITS'(sum) + ADD_BITS'(len);
        if (s > ADD_BITS'(SUM_MAX)) begin
            return SUM_MAX;
        end
        return SUM_BITS'(s);
    endfunction

    function automatic logic [OUT_BITS-1:0] out_clamp(input logic [SUM_BITS-1:0] sum);
        logic [OC_BITS-1:0] ext;
        ext = OC_BITS'(sum);
        if (ext > OC_BITS'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return OUT_BITS'(ext);
    endfunction

    function automatic logic [CLIP_BITS-1:0] clip_clamp(input logic [RUN_BITS-1:0] len);
        logic [CC_BITS-1:0] ext;
        ext = CC_BITS'(len);
        if (ext > CC_BITS'(CLIP_MAX)) begin
            return CLIP_MAX;
        end
        return CLIP_BITS'(ext);
    endfunction

endpackage

`default_nettype wire

>>> design/cigar_string_metrics.sv
// Top level of the CIGAR string metrics block: input stage, parser, result register.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   i_s_axis_tvalid/tready  tdata = cigar_char, tlast = last_char
//  m_axis    out  o_m_axis_tvalid/tready  tdata = ref_span, query_length,
//                                         clip_left, clip_right; tuser = dangling_digits
//
//  One character per cycle unless a final character waits behind an unread result;
//  each request passes the input register, then the parser, into the result register.
//  The parser state update (multiply by ten and saturating adds) sets the cycle time.
//  Synchronous active-low reset clears parser state and both valid flags.
//  A final character waits in the input register only while an unread result is held.
`timescale 1ns / 1ps
`default_nettype none

module cigar_string_metrics
    import csm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [CHAR_BITS-1:0]   i_s_axis_tdata,  // [7:0] cigar_char
    input  wire logic                   i_s_axis_tlast,  // last_char
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [31:0] ref_span, [63:32] query_length, [91:64] clip_left, [119:92] clip_right
    output logic [$bits(t_metrics_data)-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tuser   // dangling_digits
);

    t_char_req w_in_req;
    t_char_req w_stage_req;
    logic      w_stage_valid;
    logic      w_advance;
    logic      w_done;
    logic      w_out_busy;
    t_metrics  w_metrics;

    logic      r_out_valid;
    logic      n_out_valid;
    t_metrics  r_out;

    assign w_in_req.cigar_char = i_s_axis_tdata;
    assign w_in_req.last_char  = i_s_axis_tlast;

    assign w_out_busy = r_out_valid && !i_m_axis_tready;
    assign w_advance  = w_stage_valid && !(w_stage_req.last_char && w_out_busy);

    csm_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_req     (w_in_req),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_req     (w_stage_req)
    );

    csm_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_req     (w_stage_req),
        .o_done    (w_done),
        .o_metrics (w_metrics)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_done) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_metrics;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = r_out.dangling_digits;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !w_out_busy)
        else $error("result register overwritten while held");

    a_final_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage_valid && w_stage_req.last_char && w_out_busy) |-> !o_s_axis_tready)
        else $error("input accepted while final character stalled");

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_done))
        else $error("result appeared without a final character");

endmodule

`default_nettype wire

>>> design/csm_in_reg.sv
// Input register stage holding one character request for the parser.
`timescale 1ns / 1ps
`default_nettype none

module csm_in_reg
    import csm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_tvalid,
    output logic           o_tready,
    input  wire t_char_req i_req,
    input  wire logic      i_advance,
    output logic           o_valid,
    output t_char_req      o_req
);

    logic      r_valid;
    logic      n_valid;
    t_char_req r_req;
    logic      w_accept;

    assign o_tready = !r_valid || i_advance;
    assign w_accept = i_tvalid && o_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

`default_nettype wire

>>> design/csm_parse.sv
// Parser state and per-character update: run length, sums, clip tracking, metrics.
`timescale 1ns / 1ps
`default_nettype none

module csm_parse
    import csm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_char_req i_req,
    output logic           o_done,
    output t_metrics       o_metrics
);

    logic [RUN_BITS-1:0] r_run,        n_run;
    logic                r_pending,    n_pending;
    logic [SUM_BITS-1:0] r_ref_sum,    n_ref_sum;
    logic [SUM_BITS-1:0] r_query_sum,  n_query_sum;
    logic [1:0]          r_ops_seen,   n_ops_seen;
    logic                r_first_hard, n_first_hard;
    logic [RUN_BITS-1:0] r_left_clip,  n_left_clip;
    t_op_kind            r_last_kind,  n_last_kind;
    logic [RUN_BITS-1:0] r_last_len,   n_last_len;
    t_op_kind            r_prior_kind, n_prior_kind;
    logic [RUN_BITS-1:0] r_prior_len,  n_prior_len;

    logic                 w_is_digit;
    logic [3:0]           w_digit;
    logic [PROD_BITS-1:0] w_prod;
    logic                 w_is_ref;
    logic                 w_is_query;
    t_op_kind             w_kind;
    logic [RUN_BITS-1:0]  w_right;

    always_comb begin
        w_is_digit = (i_req.cigar_char >= CH_0) && (i_req.cigar_char <= CH_9);
        w_digit    = 4'(i_req.cigar_char - CH_0);
        w_prod     = PROD_BITS'(r_run) * PROD_BITS'(DEC_BASE) + PROD_BITS'(w_digit);
        w_is_ref   = (i_req.cigar_char == CH_M) || (i_req.cigar_char == CH_D) ||
                     (i_req.cigar_char == CH_N) || (i_req.cigar_char == CH_EQ) ||
                     (i_req.cigar_char == CH_X);
        w_is_query = (i_req.cigar_char == CH_M) || (i_req.cigar_char == CH_I) ||
                     (i_req.cigar_char == CH_S) || (i_req.cigar_char == CH_EQ) ||
                     (i_req.cigar_char == CH_X);
        priority if (i_req.cigar_char == CH_S) begin
            w_kind = KIND_SOFT;
        end else if (i_req.cigar_char == CH_H) begin
            w_kind = KIND_HARD;
        end else begin
            w_kind = KIND_OTHER;
        end
    end

    always_comb begin
        n_run        = r_run;
        n_pending    = r_pending;
        n_ref_sum    = r_ref_sum;
        n_query_sum  = r_query_sum;
        n_ops_seen   = r_ops_seen;
        n_first_hard = r_first_hard;
        n_left_clip  = r_left_clip;
        n_last_kind  = r_last_kind;
        n_last_len   = r_last_len;
        n_prior_kind = r_prior_kind;
        n_prior_len  = r_prior_len;

        if (i_step) begin
            if (w_is_digit) begin
                n_run     = (w_prod > PROD_BITS'(RUN_MAX)) ? RUN_MAX : RUN_BITS'(w_prod);
                n_pending = 1'b1;
            end else begin
                if (w_is_ref) begin
                    n_ref_sum = sum_sat_add(r_ref_sum, r_run);
                end
                if (w_is_query) begin
                    n_query_sum = sum_sat_add(r_query_sum, r_run);
                end
                if (r_ops_seen == 2'd0) begin
                    n_first_hard = (w_kind == KIND_HARD);
                    n_left_clip  = (w_kind == KIND_SOFT) ? r_run : '0;
                end else if ((r_ops_seen == 2'd1) && r_first_hard) begin
                    n_left_clip  = (w_kind == KIND_SOFT) ? r_run : '0;
                end
                if (r_ops_seen != 2'd2) begin
                    n_ops_seen = r_ops_seen + 2'd1;
                end
                n_prior_kind = r_last_kind;
                n_prior_len  = r_last_len;
                n_last_kind  = w_kind;
                n_last_len   = r_run;
                n_run        = '0;
                n_pending    = 1'b0;
            end
        end

        priority if ((n_last_kind == KIND_SOFT) && (n_ops_seen != 2'd0)) begin
            w_right = n_last_len;
        end else if ((n_last_kind == KIND_HARD) && (n_ops_seen == 2'd2) &&
                     (n_prior_kind == KIND_SOFT)) begin
            w_right = n_prior_len;
        end else begin
            w_right = '0;
        end

        o_metrics.data.ref_span     = out_clamp(n_ref_sum);
        o_metrics.data.query_length = out_clamp(n_query_sum);
        o_metrics.data.clip_left    = clip_clamp(n_left_clip);
        o_metrics.data.clip_right   = clip_clamp(w_right);
        o_metrics.dangling_digits   = n_pending;

        o_done = i_step && i_req.last_char;

        if (o_done) begin
            n_run        = '0;
            n_pending    = 1'b0;
            n_ref_sum    = '0;
            n_query_sum  = '0;
            n_ops_seen   = 2'd0;
            n_first_hard = 1'b0;
            n_left_clip  = '0;
            n_last_kind  = KIND_OTHER;
            n_last_len   = '0;
            n_prior_kind = KIND_OTHER;
            n_prior_len  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= '0;
            r_pending    <= 1'b0;
            r_ref_sum    <= '0;
            r_query_sum  <= '0;
            r_ops_seen   <= 2'd0;
            r_first_hard <= 1'b0;
            r_left_clip  <= '0;
            r_last_kind  <= KIND_OTHER;
            r_last_len   <= '0;
            r_prior_kind <= KIND_OTHER;
            r_prior_len  <= '0;
        end else begin
            r_run        <= n_run;
            r_pending    <= n_pending;
            r_ref_sum    <= n_ref_sum;
            r_query_sum  <= n_query_sum;
            r_ops_seen   <= n_ops_seen;
            r_first_hard <= n_first_hard;
            r_left_clip  <= n_left_clip;
            r_last_kind  <= n_last_kind;
            r_last_len   <= n_last_len;
            r_prior_kind <= n_prior_kind;
            r_prior_len  <= n_prior_len;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/cigar_metrics_checker.sv
// Checker for the CIGAR string metrics block: predicts results from accepted characters.
`timescale 1ns / 1ps

module cigar_metrics_checker
    import csm_pkg::*;
(
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_char_valid,
    input  wire logic                              i_char_ready,
    input  wire logic [CHAR_BITS-1:0]              i_char,
    input  wire logic                              i_char_last,
    input  wire logic                              i_metrics_valid,
    input  wire logic                              i_metrics_ready,
    input  wire logic [$bits(t_metrics_data)-1:0]  i_metrics_data,
    input  wire logic                              i_metrics_dangling,
    output int                                     o_error_count,
    output int                                     o_pending
);

    logic [RUN_BITS-1:0] run_len;
    logic                digits_seen;
    logic [SUM_BITS-1:0] ref_total;
    logic [SUM_BITS-1:0] query_total;
    logic [1:0]          op_count;
    logic                lead_hard;
    logic [RUN_BITS-1:0] lead_soft;
    t_op_kind            tail_kind;
    logic [RUN_BITS-1:0] tail_len;
    t_op_kind            pre_tail_kind;
    logic [RUN_BITS-1:0] pre_tail_len;

    t_metrics            metrics_due[$];
    t_metrics            due_head;
    t_metrics_data       got_data;

    assign got_data = t_metrics_data'(i_metrics_data);

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("cigar metrics mismatch at %0t: %s got %0d, expected %0d",
                 $time, what, got, want);
        o_error_count = o_error_count + 1;
    endtask

    task automatic clear_parse();
        run_len       = '0;
        digits_seen   = 1'b0;
        ref_total     = '0;
        query_total   = '0;
        op_count      = '0;
        lead_hard     = 1'b0;
        lead_soft     = '0;
        tail_kind     = KIND_OTHER;
        tail_len      = '0;
        pre_tail_kind = KIND_OTHER;
        pre_tail_len  = '0;
    endtask

    function automatic logic [SUM_BITS-1:0] sat_total(input logic [SUM_BITS-1:0] total,
                                                      input logic [RUN_BITS-1:0] len);
        logic [SUM_BITS:0] s;
        s = {1'b0, total} + (SUM_BITS+1)'(len);
        return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
    endfunction

    task automatic close_op(input logic [CHAR_BITS-1:0] c);
        t_op_kind            kind;
        logic [RUN_BITS-1:0] len;
        len  = run_len;
        kind = KIND_OTHER;
        if (c == CH_M || c == CH_D || c == CH_N || c == CH_EQ || c == CH_X) begin
            ref_total = sat_total(ref_total, len);
        end
        if (c == CH_M || c == CH_I || c == CH_S || c == CH_EQ || c == CH_X) begin
            query_total = sat_total(query_total, len);
        end
        if (c == CH_S) begin
            kind = KIND_SOFT;
        end else if (c == CH_H) begin
            kind = KIND_HARD;
        end
        if (op_count == 2'd0) begin
            lead_hard = (kind == KIND_HARD);
            lead_soft = (kind == KIND_SOFT) ? len : '0;
        end else if (op_count == 2'd1 && lead_hard) begin
            lead_soft = (kind == KIND_SOFT) ? len : '0;
        end
        if (op_count < 2'd2) begin
            op_count = op_count + 2'd1;
        end
        pre_tail_kind = tail_kind;
        pre_tail_len  = tail_len;
        tail_kind     = kind;
        tail_len      = len;
        run_len       = '0;
        digits_seen   = 1'b0;
    endtask

    task automatic absorb_char(input logic [CHAR_BITS-1:0] c, input logic last);
        logic [RUN_BITS+4:0] scaled;
        t_metrics            want;
        if (c >= CH_0 && c <= CH_9) begin
            scaled = (RUN_BITS+5)'(run_len) * 10 + (RUN_BITS+5)'(c - CH_0);
            run_len = (scaled > (RUN_BITS+5)'(RUN_MAX)) ? RUN_MAX : scaled[RUN_BITS-1:0];
            digits_seen = 1'b1;
        end else begin
            close_op(c);
        end
        if (last) begin
            want.dangling_digits   = digits_seen;
            want.data.ref_span     = OUT_BITS'(ref_total);
            want.data.query_length = OUT_BITS'(query_total);
            want.data.clip_left    = CLIP_BITS'(lead_soft);
            want.data.clip_right   = '0;
            if (tail_kind == KIND_SOFT && op_count >= 2'd1) begin
                want.data.clip_right = CLIP_BITS'(tail_len);
            end else if (tail_kind == KIND_HARD && op_count >= 2'd2
                         && pre_tail_kind == KIND_SOFT) begin
                want.data.clip_right = CLIP_BITS'(pre_tail_len);
            end
            metrics_due.push_back(want);
            clear_parse();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            metrics_due.delete();
        end else begin
            if (i_char_valid && i_char_ready) begin
                absorb_char(i_char, i_char_last);
            end
            if (i_metrics_valid && i_metrics_ready) begin
                if (metrics_due.size() == 0) begin
                    report_mismatch("result with none expected, ref_span",
                                    64'(got_data.ref_span), 64'd0);
                end else begin
                    due_head = metrics_due.pop_front();
                    if (got_data.ref_span !== due_head.data.ref_span) begin
                        report_mismatch("ref_span", 64'(got_data.ref_span),
                                        64'(due_head.data.ref_span));
                    end
                    if (got_data.query_length !== due_head.data.query_length) begin
                        report_mismatch("query_length", 64'(got_data.query_length),
                                        64'(due_head.data.query_length));
                    end
                    if (got_data.clip_left !== due_head.data.clip_left) begin
                        report_mismatch("clip_left", 64'(got_data.clip_left),
                                        64'(due_head.data.clip_left));
                    end
                    if (got_data.clip_right !== due_head.data.clip_right) begin
                        report_mismatch("clip_right", 64'(got_data.clip_right),
                                        64'(due_head.data.clip_right));
                    end
                    if (i_metrics_dangling !== due_head.dangling_digits) begin
                        report_mismatch("dangling_digits", 64'(i_metrics_dangling),
                                        64'(due_head.dangling_digits));
                    end
                end
            end
        end
        o_pending = metrics_due.size();
    end

endmodule

>>> tb/sv/tb_cigar_string_metrics.sv
// Testbench top for the CIGAR string metrics block: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module tb_cigar_string_metrics;
    import csm_pkg::*;

    localparam int                   CLK_HALF_NS  = 6;
    localparam int                   RANDOM_CHARS = 1450;
    localparam int                   STALL_LIMIT  = 4000;
    localparam int                   DRAIN_CYCLES = 8;
    localparam logic [CHAR_BITS-1:0] CH_PAD       = 8'h50;

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              char_valid = 1'b0;
    logic                              char_ready;
    logic [CHAR_BITS-1:0]              char_data  = '0;
    logic                              char_last  = 1'b0;
    logic                              m_valid;
    logic                              m_ready    = 1'b0;
    logic [$bits(t_metrics_data)-1:0]  m_data;
    logic                              m_dangling;

    int                                error_count;
    int                                pending;
    int                                idle_pct   = 0;
    int                                stall_pct  = 0;
    int                                chars_sent = 0;
    int                                quiet_cycles = 0;
    logic [CHAR_BITS-1:0]              cigar_text[$];

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    cigar_string_metrics DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (char_valid),
        .o_s_axis_tready (char_ready),
        .i_s_axis_tdata  (char_data),
        .i_s_axis_tlast  (char_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_dangling)
    );

    cigar_metrics_checker u_metrics_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_char_valid       (char_valid),
        .i_char_ready       (char_ready),
        .i_char             (char_data),
        .i_char_last        (char_last),
        .i_metrics_valid    (m_valid),
        .i_metrics_ready    (m_ready),
        .i_metrics_data     (m_data),
        .i_metrics_dangling (m_dangling),
        .o_error_count      (error_count),
        .o_pending          (pending)
    );

    always @(negedge clk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (char_valid && char_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_cigar_string_metrics: errors");
            $finish;
        end
    end

    task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= c;
        char_last  <= last;
        @(posedge clk);
        while (!char_ready) begin
            @(posedge clk);
        end
        chars_sent = chars_sent + 1;
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < cigar_text.size(); i++) begin
            send_char(cigar_text[i], i == cigar_text.size() - 1);
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            cigar_text.push_back(s[i]);
        end
    endtask

    task automatic send_cigar(input string s);
        cigar_text.delete();
        add_text(s);
        send_text();
    endtask

    task automatic add_digits(input int count);
        repeat (count) cigar_text.push_back(CH_0 + 8'($urandom_range(0, 9)));
    endtask

    // Mostly short runs; some bare operations and some runs long enough to saturate.
    task automatic add_run(input logic [CHAR_BITS-1:0] op);
        int digits;
        case ($urandom_range(0, 19))
            0, 1: begin
                digits = 0;
            end
            2: begin
                digits = $urandom_range(9, 11);
            end
            default: begin
                digits = $urandom_range(1, 3);
            end
        endcase
        add_digits(digits);
        cigar_text.push_back(op);
    endtask

    function automatic logic [CHAR_BITS-1:0] pick_body_op();
        case ($urandom_range(0, 10))
            0, 1, 2: return CH_M;
            3:       return CH_I;
            4:       return CH_D;
            5:       return CH_N;
            6:       return CH_EQ;
            7:       return CH_X;
            8:       return CH_S;
            9:       return CH_H;
            default: return CH_PAD;
        endcase
    endfunction

    task automatic build_cigar();
        cigar_text.delete();
        if ($urandom_range(0, 2) == 0) begin
            add_run(CH_H);
        end
        if ($urandom_range(0, 1) == 0) begin
            add_run(CH_S);
        end
        repeat ($urandom_range(0, 6)) add_run(pick_body_op());
        if ($urandom_range(0, 1) == 0) begin
            add_run(CH_S);
        end
        if ($urandom_range(0, 2) == 0) begin
            add_run(CH_H);
        end
        if (cigar_text.size() == 0 || $urandom_range(0, 9) == 0) begin
            add_digits($urandom_range(1, 3));
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12)) begin
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        int random_start;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_cigar("10M");
        send_cigar("5S10M3S");
        send_cigar("2H4S10M6S3H");
        send_cigar("7H");
        send_cigar("3H2H");
        send_cigar("12");
        send_cigar("M");
        send_cigar("4S");
        send_cigar("3P");
        send_cigar("1M2I3D4N5=6X7S");
        send_cigar("9999999999M");
        send_cigar("4S3M12");
        send_cigar("2H3M");
        send_cigar("5S2H");
        send_char('0, 1'b1);
        send_char('1, 1'b1);
        cigar_text.delete();
        repeat (17) add_text("268435455=");
        add_text("268435455I");
        send_text();

        random_start = chars_sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default: begin
                    idle_pct  = 16;
                    stall_pct = 16;
                end
            endcase
            while (chars_sent < random_start + (phase + 1) * RANDOM_CHARS / 4) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_noise();
                end else begin
                    build_cigar();
                    send_text();
                end
            end
        end
        char_valid <= 1'b0;

        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0) begin
            $display("tb_cigar_string_metrics: clean");
        end else begin
            $display("tb_cigar_string_metrics: errors");
        end
        $finish;
    end

endmodule
